// File: hw/rtl/ttok_pkg.sv
// Package for the toy language tokenizer.
// Holds token kinds, error codes, character constants and the result word type.
// Depends on nothing; the top level, scanner, queue and checker import it.
`default_nettype none

package ttok_pkg;

	localparam logic [4:0] K_IDENT   = 5'd0;
	localparam logic [4:0] K_NUMBER  = 5'd1;
	localparam logic [4:0] K_LITERAL = 5'd2;
	localparam logic [4:0] K_PLUS    = 5'd3;
	localparam logic [4:0] K_MINUS   = 5'd4;
	localparam logic [4:0] K_STAR    = 5'd5;
	localparam logic [4:0] K_SLASH   = 5'd6;
	localparam logic [4:0] K_LPAREN  = 5'd7;
	localparam logic [4:0] K_RPAREN  = 5'd8;
	localparam logic [4:0] K_SEMI    = 5'd9;
	localparam logic [4:0] K_COMMA   = 5'd10;
	localparam logic [4:0] K_LBRACK  = 5'd11;
	localparam logic [4:0] K_RBRACK  = 5'd12;
	localparam logic [4:0] K_LT      = 5'd13;
	localparam logic [4:0] K_NE      = 5'd14;
	localparam logic [4:0] K_LE      = 5'd15;
	localparam logic [4:0] K_GT      = 5'd16;
	localparam logic [4:0] K_GE      = 5'd17;
	localparam logic [4:0] K_ASSIGN  = 5'd18;
	localparam logic [4:0] K_EQ      = 5'd19;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_IDENT_LONG = 3'd1;
	localparam logic [2:0] ERR_NUM_CHAR   = 3'd2;
	localparam logic [2:0] ERR_NUM_EOL    = 3'd3;
	localparam logic [2:0] ERR_NUM_EOF    = 3'd4;
	localparam logic [2:0] ERR_LIT_EOL    = 3'd5;
	localparam logic [2:0] ERR_LIT_EOF    = 3'd6;
	localparam logic [2:0] ERR_UNEXPECTED = 3'd7;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GREAT  = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_E_UP   = 8'h45;
	localparam logic [7:0] CH_E_LOW  = 8'h65;

	typedef struct packed {
		logic       has_token;
		logic [4:0] token_kind;
		logic [7:0] token_length;
		logic [15:0] line_number;
		logic [2:0] error_kind;
		logic       last;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttok_if.sv
// Handshake interfaces of the tokenizer: source bytes in, result words out.
// Depends on nothing; widths follow the fields of one word.
`default_nettype none

interface ttok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ttok_out_if;
	logic        valid;
	logic        ready;
	logic        has_token;
	logic [4:0]  token_kind;
	logic [7:0]  token_length;
	logic [15:0] line_number;
	logic [2:0]  error_kind;
	logic        last;

	modport source (output valid, output has_token, output token_kind, output token_length,
		output line_number, output error_kind, output last, input ready);
	modport sink (input valid, input has_token, input token_kind, input token_length,
		input line_number, input error_kind, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/toy_language_tokenizer.sv
// Top level of the tokenizer: input register, scanner core and result queue.
// Depends on ttok_pkg, ttok_if, ttok_scan and ttok_outq.
//
// Takes one source byte per word and returns result words for tokens. A byte
// passes the input register and is scanned combinationally, so a new byte is
// accepted every cycle while the output side keeps up; one byte can yield two
// words (a pending token that it ends plus a token of its own), and the output
// delivers one word per cycle, while ready is high, from a four-entry queue,
// so such bytes can fill the queue and hold back input.
`default_nettype none

module toy_language_tokenizer #(
	parameter int MAX_IDENT_LEN = 30
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ttok_in_if.sink     chars,
	ttok_out_if.source  tokens
);
	import ttok_pkg::*;

	logic       v_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       room;
	logic       fire;
	push_t      push;

	assign fire        = v_s1 && room;
	assign chars.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			eoi_s1  <= chars.end_of_input;
		end
	end

	ttok_scan #(
		.MAX_IDENT_LEN(MAX_IDENT_LEN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.char_code   (char_s1),
		.end_of_input(eoi_s1),
		.push        (push)
	);

	ttok_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.tokens(tokens)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ttok_scan.sv
// Scanner core: mode, number sub-state, length and line registers plus the
// one-pass next-state logic that yields up to two result words per byte.
// Depends on ttok_pkg.
`default_nettype none

module ttok_scan #(
	parameter int MAX_IDENT_LEN = 30
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic [7:0]     char_code,
	input  wire logic           end_of_input,
	output ttok_pkg::push_t     push
);
	import ttok_pkg::*;

	typedef enum logic [8:0] {
		M_IDLE    = 9'b000000001,
		M_IDENT   = 9'b000000010,
		M_NUMBER  = 9'b000000100,
		M_LITERAL = 9'b000001000,
		M_SLASH   = 9'b000010000,
		M_COMMENT = 9'b000100000,
		M_LESS    = 9'b001000000,
		M_GREATER = 9'b010000000,
		M_EQUAL   = 9'b100000000
	} mode_t;

	typedef enum logic [5:0] {
		N_INT  = 6'b000001,
		N_DOT  = 6'b000010,
		N_FRAC = 6'b000100,
		N_EXP  = 6'b001000,
		N_SIGN = 6'b010000,
		N_EXPD = 6'b100000
	} num_t;

	localparam logic [7:0] MaxLen = 8'(MAX_IDENT_LEN);

	mode_t       mode_q, mode_d;
	num_t        num_q, num_d;
	logic [7:0]  len_q, len_d, len_inc;
	logic [15:0] line_q, line_d, line_inc;
	logic        ovf_q, ovf_d;
	logic        pend_v, idle_v, rescan, to_idle;
	res_t        pend_r, idle_r;
	logic        is_alpha, is_digit, is_e, is_nl;

	function automatic res_t mk(logic has, logic [4:0] kind, logic [7:0] len,
		logic [15:0] line, logic [2:0] err);
		res_t r;
		r.has_token    = has;
		r.token_kind   = kind;
		r.token_length = len;
		r.line_number  = line;
		r.error_kind   = err;
		r.last         = 1'b0;
		return r;
	endfunction

	assign is_alpha = (char_code >= 8'h61 && char_code <= 8'h7A) ||
		(char_code >= 8'h41 && char_code <= 8'h5A);
	assign is_digit = char_code >= 8'h30 && char_code <= 8'h39;
	assign is_e     = char_code == CH_E_LOW || char_code == CH_E_UP;
	assign is_nl    = char_code == CH_NL;
	assign len_inc  = (len_q == 8'hFF) ? len_q : len_q + 8'd1;
	assign line_inc = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;

	always_comb begin
		mode_d  = mode_q;
		num_d   = num_q;
		len_d   = len_q;
		line_d  = line_q;
		ovf_d   = ovf_q;
		pend_v  = 1'b0;
		idle_v  = 1'b0;
		rescan  = 1'b0;
		to_idle = 1'b0;
		pend_r  = mk(1'b0, K_IDENT, 8'd0, line_q, ERR_NONE);
		idle_r  = pend_r;
		if (end_of_input) begin
			to_idle = 1'b1;
			case (mode_q)
				M_IDENT: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_IDENT, len_q, line_q,
						ovf_q ? ERR_IDENT_LONG : ERR_NONE);
				end
				M_NUMBER: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_NUMBER, len_q, line_q,
						(num_q == N_DOT || num_q == N_EXP || num_q == N_SIGN) ?
						ERR_NUM_EOF : ERR_NONE);
				end
				M_LITERAL: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_LITERAL, len_q, line_q, ERR_LIT_EOF);
				end
				M_SLASH: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_SLASH, 8'd1, line_q, ERR_NONE);
				end
				M_LESS: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_LT, 8'd1, line_q, ERR_NONE);
				end
				M_GREATER: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_GT, 8'd1, line_q, ERR_NONE);
				end
				M_EQUAL: begin
					pend_v = 1'b1;
					pend_r = mk(1'b1, K_ASSIGN, 8'd1, line_q, ERR_NONE);
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alpha || is_digit) begin
						if (len_q < MaxLen) len_d = len_q + 8'd1;
						else ovf_d = 1'b1;
					end else begin
						pend_v = 1'b1;
						pend_r = mk(1'b1, K_IDENT, len_q, line_q,
							ovf_q ? ERR_IDENT_LONG : ERR_NONE);
						rescan = 1'b1;
					end
				end
				M_NUMBER: begin
					if (num_q == N_INT || num_q == N_FRAC || num_q == N_EXPD) begin
						if (is_digit) begin
							len_d = len_inc;
						end else if (num_q == N_INT && char_code == CH_DOT) begin
							len_d = len_inc;
							num_d = N_DOT;
						end else if (num_q != N_EXPD && is_e) begin
							len_d = len_inc;
							num_d = N_EXP;
						end else begin
							pend_v = 1'b1;
							pend_r = mk(1'b1, K_NUMBER, len_q, line_q, ERR_NONE);
							rescan = 1'b1;
						end
					end else begin
						if (is_digit) begin
							len_d = len_inc;
							num_d = (num_q == N_DOT) ? N_FRAC : N_EXPD;
						end else if (num_q == N_EXP &&
							(char_code == CH_PLUS || char_code == CH_MINUS)) begin
							len_d = len_inc;
							num_d = N_SIGN;
						end else begin
							pend_v = 1'b1;
							pend_r = mk(1'b1, K_NUMBER, len_q, line_q,
								is_nl ? ERR_NUM_EOL : ERR_NUM_CHAR);
							rescan = 1'b1;
						end
					end
				end
				M_LITERAL: begin
					if (char_code == CH_QUOTE) begin
						pend_v  = 1'b1;
						pend_r  = mk(1'b1, K_LITERAL, len_inc, line_q, ERR_NONE);
						to_idle = 1'b1;
					end else if (is_nl) begin
						line_d  = line_inc;
						pend_v  = 1'b1;
						pend_r  = mk(1'b1, K_LITERAL, len_q, line_inc, ERR_LIT_EOL);
						to_idle = 1'b1;
					end else begin
						len_d = len_inc;
					end
				end
				M_SLASH: begin
					if (char_code == CH_SLASH) begin
						mode_d = M_COMMENT;
						len_d  = 8'd0;
					end else begin
						pend_v = 1'b1;
						pend_r = mk(1'b1, K_SLASH, 8'd1, line_q, ERR_NONE);
						rescan = 1'b1;
					end
				end
				M_COMMENT: begin
					if (is_nl) begin
						line_d  = line_inc;
						to_idle = 1'b1;
					end
				end
				M_LESS: begin
					pend_v = 1'b1;
					if (char_code == CH_GREAT) begin
						pend_r  = mk(1'b1, K_NE, 8'd2, line_q, ERR_NONE);
						to_idle = 1'b1;
					end else if (char_code == CH_EQUAL) begin
						pend_r  = mk(1'b1, K_LE, 8'd2, line_q, ERR_NONE);
						to_idle = 1'b1;
					end else begin
						pend_r = mk(1'b1, K_LT, 8'd1, line_q, ERR_NONE);
						rescan = 1'b1;
					end
				end
				M_GREATER: begin
					pend_v = 1'b1;
					if (char_code == CH_EQUAL) begin
						pend_r  = mk(1'b1, K_GE, 8'd2, line_q, ERR_NONE);
						to_idle = 1'b1;
					end else begin
						pend_r = mk(1'b1, K_GT, 8'd1, line_q, ERR_NONE);
						rescan = 1'b1;
					end
				end
				M_EQUAL: begin
					pend_v = 1'b1;
					if (char_code == CH_EQUAL) begin
						pend_r  = mk(1'b1, K_EQ, 8'd2, line_q, ERR_NONE);
						to_idle = 1'b1;
					end else begin
						pend_r = mk(1'b1, K_ASSIGN, 8'd1, line_q, ERR_NONE);
						rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase
		end

		if (to_idle || rescan) begin
			mode_d = M_IDLE;
			num_d  = N_INT;
			len_d  = 8'd0;
			ovf_d  = 1'b0;
		end

		if (rescan) begin
			if (char_code == CH_SPACE || char_code == CH_TAB) begin
				idle_v = 1'b0;
			end else if (is_nl) begin
				line_d = line_inc;
			end else if (is_alpha) begin
				mode_d = M_IDENT;
				len_d  = 8'd1;
			end else if (is_digit) begin
				mode_d = M_NUMBER;
				len_d  = 8'd1;
			end else begin
				idle_v = 1'b1;
				case (char_code)
					CH_PLUS:   idle_r = mk(1'b1, K_PLUS, 8'd1, line_q, ERR_NONE);
					CH_MINUS:  idle_r = mk(1'b1, K_MINUS, 8'd1, line_q, ERR_NONE);
					CH_STAR:   idle_r = mk(1'b1, K_STAR, 8'd1, line_q, ERR_NONE);
					CH_LPAREN: idle_r = mk(1'b1, K_LPAREN, 8'd1, line_q, ERR_NONE);
					CH_RPAREN: idle_r = mk(1'b1, K_RPAREN, 8'd1, line_q, ERR_NONE);
					CH_SEMI:   idle_r = mk(1'b1, K_SEMI, 8'd1, line_q, ERR_NONE);
					CH_COMMA:  idle_r = mk(1'b1, K_COMMA, 8'd1, line_q, ERR_NONE);
					CH_LBRACK: idle_r = mk(1'b1, K_LBRACK, 8'd1, line_q, ERR_NONE);
					CH_RBRACK: idle_r = mk(1'b1, K_RBRACK, 8'd1, line_q, ERR_NONE);
					CH_SLASH: begin
						idle_v = 1'b0;
						mode_d = M_SLASH;
						len_d  = 8'd1;
					end
					CH_LESS: begin
						idle_v = 1'b0;
						mode_d = M_LESS;
						len_d  = 8'd1;
					end
					CH_GREAT: begin
						idle_v = 1'b0;
						mode_d = M_GREATER;
						len_d  = 8'd1;
					end
					CH_EQUAL: begin
						idle_v = 1'b0;
						mode_d = M_EQUAL;
						len_d  = 8'd1;
					end
					CH_QUOTE: begin
						idle_v = 1'b0;
						mode_d = M_LITERAL;
						len_d  = 8'd1;
					end
					default: idle_r = mk(1'b0, K_IDENT, 8'd1, line_q, ERR_UNEXPECTED);
				endcase
			end
		end
	end

	always_comb begin
		push.v0      = fire && (pend_v || idle_v);
		push.v1      = fire && pend_v && idle_v;
		push.r0      = pend_v ? pend_r : idle_r;
		push.r0.last = !(pend_v && idle_v);
		push.r1      = idle_r;
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			num_q  <= N_INT;
			len_q  <= 8'd0;
			line_q <= 16'd1;
			ovf_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			num_q  <= num_d;
			len_q  <= len_d;
			line_q <= line_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ttok_outq.sv
// Four-entry result queue: takes up to two words per cycle from the scanner
// and hands one word per cycle to the output channel while it is ready.
// Depends on ttok_pkg and ttok_if.
`default_nettype none

module ttok_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ttok_pkg::push_t    push,
	output logic               room,
	ttok_out_if.source         tokens
);
	import ttok_pkg::*;

	localparam int Depth = 4;
	localparam int Aw    = $clog2(Depth);

	res_t          mem [Depth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0]   count_q;
	logic          pop;
	logic [Aw:0]   n_push;
	res_t          head;

	assign pop    = tokens.valid && tokens.ready;
	assign n_push = (Aw+1)'(push.v0) + (Aw+1)'(push.v1);
	assign room   = count_q <= (Aw+1)'(Depth - 2);
	assign head   = mem[rd_q];

	assign tokens.valid        = count_q != '0;
	assign tokens.has_token    = head.has_token;
	assign tokens.token_kind   = head.token_kind;
	assign tokens.token_length = head.token_length;
	assign tokens.line_number  = head.line_number;
	assign tokens.error_kind   = head.error_kind;
	assign tokens.last         = head.last;

	always_ff @(posedge clk) begin
		if (push.v0) mem[wr_q] <= push.r0;
		if (push.v1) mem[wr_q + Aw'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[Aw-1:0];
			rd_q    <= rd_q + Aw'(pop);
			count_q <= count_q + n_push - (Aw+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ttok_checker.sv
// Port-level checks for the tokenizer, attached to the top level by bind.
// Depends on ttok_pkg.
`default_nettype none

module ttok_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        has_token,
	input wire logic [4:0]  token_kind,
	input wire logic [7:0]  token_length,
	input wire logic [15:0] line_number,
	input wire logic [2:0]  error_kind
);
	import ttok_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(line_number))
		else $error("result word dropped or changed while stalled");

	a_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_token |-> error_kind == ERR_UNEXPECTED && token_length == 8'd1)
		else $error("word without token is not an unexpected character");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 16'd0 && token_kind <= K_EQ)
		else $error("line number or token kind out of range");

	a_line_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |-> line_number >= $past(line_number))
		else $error("line number went backwards");

endmodule

bind toy_language_tokenizer ttok_checker u_ttok_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.has_token   (tokens.has_token),
	.token_kind  (tokens.token_kind),
	.token_length(tokens.token_length),
	.line_number (tokens.line_number),
	.error_kind  (tokens.error_kind)
);

`default_nettype wire
